[sv/keyed_priority_queue_upsert_unit_defines.svh]
// Assertion macros for the checker file of the keyed priority queue.
// Depends on nothing; include by bare file name.
`ifndef KEYED_PRIORITY_QUEUE_UPSERT_UNIT_DEFINES_SVH
`define KEYED_PRIORITY_QUEUE_UPSERT_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define KPQ_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define KPQ_CHECK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define KPQ_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/kpq_pkg.sv]
// Package of the keyed priority queue: sizes, entry and control types, op codes.
// No dependencies.
package kpq_pkg;

   localparam int CAPACITY      = 64;
   localparam int KEY_PART_BITS = 16;
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
   localparam int FUNC_BITS     = 3;

   typedef logic [KEY_PART_BITS-1:0] key_part_type;
   typedef logic [COUNT_BITS-1:0]    count_type;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_INSERT   = 3'd0,
      FUNC_TAKE     = 3'd1,
      FUNC_PEEK     = 3'd2,
      FUNC_CONTAINS = 3'd3,
      FUNC_CLEAR    = 3'd4
   } func_type;

   typedef struct packed {
      logic         valid;
      key_part_type depth;
      key_part_type id;
      logic         force_flag;
   } entry_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic         apply;
      func_type     func;
      key_part_type depth;
      key_part_type id;
      logic         force_flag;
      logic         any_eq;
      logic         full;
   } cell_ctrl_type;

   typedef struct packed {
      logic         found;
      key_part_type out_depth;
      key_part_type out_id;
      logic         out_force;
      logic         new_entry;
      logic         overflow;
      count_type    count;
   } rsp_type;

endpackage

[sv/kpq_if.sv]
// Valid/ready channel interfaces for request and response beats.
// Depends on kpq_pkg.
interface kpq_req_if;
   logic                 valid;
   logic                 ready;
   logic [2:0]           func;
   kpq_pkg::key_part_type key_depth;
   kpq_pkg::key_part_type key_id;
   logic                 force_in;

   modport source (output valid, func, key_depth, key_id, force_in, input ready);
   modport sink   (input valid, func, key_depth, key_id, force_in, output ready);
endinterface

interface kpq_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  found;
   kpq_pkg::key_part_type out_depth;
   kpq_pkg::key_part_type out_id;
   logic                  out_force;
   logic                  new_entry;
   logic                  overflow;
   kpq_pkg::count_type    count;

   modport source (output valid, found, out_depth, out_id, out_force, new_entry,
                   overflow, count, input ready);
   modport sink   (input valid, found, out_depth, out_id, out_force, new_entry,
                   overflow, count, output ready);
endinterface

[sv/keyed_priority_queue_upsert_unit.sv]
// Keyed priority queue with upsert: the response beat to each request beat is registered.
// Throughput one operation per cycle while the response side takes its beats; the op is
// broadcast to a row of CAPACITY cells that compare and shift in that same cycle.
// Reset (synchronous) empties the queue at once: cell valid bits and count clear, no sweep.
module keyed_priority_queue_upsert_unit (
   input logic     clock,
   input logic     reset,
   kpq_req_if.sink   req_bus,
   kpq_rsp_if.source rsp_bus
);
   import kpq_pkg::*;

   // request side
   logic          req_ready;
   logic          accept;
   func_type      func;
   cell_ctrl_type ctrl;

   // cell row
   entry_type     cell_entry [CAPACITY];
   entry_type     cell_left  [CAPACITY];
   entry_type     cell_right [CAPACITY];
   logic [CAPACITY-1:0] cell_lt;
   logic [CAPACITY-1:0] cell_left_lt;
   logic [CAPACITY-1:0] cell_eq;
   logic [CAPACITY-1:0] cell_unforced;

   logic          any_eq;
   logic          raise;
   logic          full;

   // state and response
   count_type     count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // Take a request beat whenever the response register is empty or drains now.
   assign req_ready     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = req_ready;
   assign accept        = req_bus.valid && req_ready;
   assign func          = func_type'(req_bus.func);

   assign full   = (count_ff == COUNT_BITS'(CAPACITY));
   assign any_eq = |cell_eq;
   // matched entry had force clear and the insert sets it
   assign raise  = (|(cell_eq & cell_unforced)) && req_bus.force_in;

   assign ctrl = '{apply:      accept,
                   func:       func,
                   depth:      req_bus.key_depth,
                   id:         req_bus.key_id,
                   force_flag: req_bus.force_in,
                   any_eq:     any_eq,
                   full:       full};

   // Wire the row: cell 0 sees an always-less left neighbor so that it is the
   // insertion point when the new key is least; the last cell pulls in an empty slot.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_left[i]    = '0;
         assign cell_left_lt[i] = 1'b1;
      end else begin : g_body
         assign cell_left[i]    = cell_entry[i-1];
         assign cell_left_lt[i] = cell_lt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign cell_right[i] = '0;
      end else begin : g_mid
         assign cell_right[i] = cell_entry[i+1];
      end
      assign cell_unforced[i] = !cell_entry[i].force_flag;

      kpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (cell_left[i]),
         .left_lt     (cell_left_lt[i]),
         .right_entry (cell_right[i]),
         .entry       (cell_entry[i]),
         .lt          (cell_lt[i]),
         .eq          (cell_eq[i])
      );
   end

   // Next count and response fields; fields without meaning for the op stay zero.
   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      case (func)
         FUNC_INSERT: begin
            if (any_eq) begin
               rsp_in.new_entry = raise;
            end else if (full) begin
               rsp_in.overflow = 1'b1;
            end else begin
               rsp_in.new_entry = 1'b1;
               count_in         = count_ff + COUNT_BITS'(1);
            end
         end
         FUNC_TAKE, FUNC_PEEK: begin
            if (cell_entry[0].valid) begin
               rsp_in.found     = 1'b1;
               rsp_in.out_depth = cell_entry[0].depth;
               rsp_in.out_id    = cell_entry[0].id;
               rsp_in.out_force = cell_entry[0].force_flag;
               if (func == FUNC_TAKE) begin
                  count_in = count_ff - COUNT_BITS'(1);
               end
            end
         end
         FUNC_CONTAINS: begin
            rsp_in.found = any_eq;
         end
         FUNC_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      rsp_in.count = count_in;
   end

   // Hold the response until taken; load a fresh one on every accepted beat.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.found     = rsp_ff.found;
   assign rsp_bus.out_depth = rsp_ff.out_depth;
   assign rsp_bus.out_id    = rsp_ff.out_id;
   assign rsp_bus.out_force = rsp_ff.out_force;
   assign rsp_bus.new_entry = rsp_ff.new_entry;
   assign rsp_bus.overflow  = rsp_ff.overflow;
   assign rsp_bus.count     = rsp_ff.count;

endmodule

[sv/kpq_cell.sv]
// One slot of the sorted cell row: holds one entry, compares it with the
// broadcast key and shifts to or from its neighbors. Depends on kpq_pkg.
module kpq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  kpq_pkg::cell_ctrl_type ctrl,
   input  kpq_pkg::entry_type     left_entry,
   input  logic                   left_lt,
   input  kpq_pkg::entry_type     right_entry,
   output kpq_pkg::entry_type     entry,
   output logic                   lt,
   output logic                   eq
);
   import kpq_pkg::*;

   logic         valid_ff, valid_in;
   key_part_type depth_ff, depth_in;
   key_part_type id_ff, id_in;
   logic         flag_ff, flag_in;

   assign entry = '{valid: valid_ff, depth: depth_ff, id: id_ff, force_flag: flag_ff};
   assign eq    = valid_ff && (depth_ff == ctrl.depth) && (id_ff == ctrl.id);
   assign lt    = valid_ff && ({depth_ff, id_ff} < {ctrl.depth, ctrl.id});

   always_comb begin
      valid_in = valid_ff;
      depth_in = depth_ff;
      id_in    = id_ff;
      flag_in  = flag_ff;
      if (ctrl.apply) begin
         case (ctrl.func)
            FUNC_INSERT: begin
               if (ctrl.any_eq) begin
                  if (eq) begin
                     flag_in = ctrl.force_flag;
                  end
               end else if (!ctrl.full && !lt) begin
                  if (left_lt) begin
                     // insertion point: load the new key
                     valid_in = 1'b1;
                     depth_in = ctrl.depth;
                     id_in    = ctrl.id;
                     flag_in  = ctrl.force_flag;
                  end else begin
                     // behind the insertion point: shift right by one
                     valid_in = left_entry.valid;
                     depth_in = left_entry.depth;
                     id_in    = left_entry.id;
                     flag_in  = left_entry.force_flag;
                  end
               end
            end
            FUNC_TAKE: begin
               valid_in = right_entry.valid;
               depth_in = right_entry.depth;
               id_in    = right_entry.id;
               flag_in  = right_entry.force_flag;
            end
            FUNC_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      depth_ff <= depth_in;
      id_ff    <= id_in;
      flag_ff  <= flag_in;
   end

endmodule

[sv/kpq_checker.sv]
// Port-level checks of the keyed priority queue and the bind that attaches them.
// Depends on kpq_pkg and keyed_priority_queue_upsert_unit_defines.svh.
`include "keyed_priority_queue_upsert_unit_defines.svh"

module kpq_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [2:0]            req_func,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_found,
   input logic                  rsp_new_entry,
   input logic                  rsp_overflow,
   input kpq_pkg::count_type    rsp_count
);
   import kpq_pkg::*;

   `KPQ_CHECK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count), "stalled response beat changed")
   `KPQ_CHECK_IMPLY(a_count_bound, clock, reset, rsp_valid, rsp_count <= COUNT_BITS'(CAPACITY), "count beyond capacity")
   `KPQ_CHECK_IMPLY(a_overflow_full, clock, reset, rsp_valid && rsp_overflow, rsp_count == COUNT_BITS'(CAPACITY) && !rsp_new_entry, "overflow without a full queue")
   `KPQ_CHECK(a_new_not_found, clock, reset, !(rsp_valid && rsp_new_entry && rsp_found), "insert and lookup flags together")
   `KPQ_CHECK_NEXT(a_clear_empty, clock, reset, req_valid && req_ready && req_func == FUNC_CLEAR, rsp_valid && rsp_count == '0, "clear did not empty the queue")

endmodule

bind keyed_priority_queue_upsert_unit kpq_checker u_kpq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_func      (req_bus.func),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_found     (rsp_bus.found),
   .rsp_new_entry (rsp_bus.new_entry),
   .rsp_overflow  (rsp_bus.overflow),
   .rsp_count     (rsp_bus.count)
);
